[hdl/disc_time_to_collision_top_defines.svh]
// ----------------------------------------------------------------------------
// disc_time_to_collision_top_defines
// Assertion macros shared by the disc time-to-collision block.
// ----------------------------------------------------------------------------
`ifndef DISC_TIME_TO_COLLISION_TOP_DEFINES_SVH
`define DISC_TIME_TO_COLLISION_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DTTC_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dttc assertion failed");

// Next-cycle implication, disabled during reset.
`define DTTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dttc assertion failed");

`endif

[hdl/dttc_pkg.sv]
// ----------------------------------------------------------------------------
// dttc_pkg
// Types and constants of the disc time-to-collision block.
// ----------------------------------------------------------------------------
`default_nettype none

package dttc_pkg;

    localparam int ROOT_W = 34;   // floor square root of the discriminant
    localparam int F_W    = 68;   // discriminant and its products
    localparam int QUOT_W = 24;   // time quotient
    localparam int NUM_W  = 42;   // (d - s) shifted by eight

    localparam logic [1:0]  OUTCOME_OVERLAP = 2'd0;
    localparam logic [1:0]  OUTCOME_AHEAD   = 2'd1;
    localparam logic [1:0]  OUTCOME_NONE    = 2'd2;
    localparam logic [23:0] TIME_MAX        = 24'hFFFFFF;

    typedef struct packed {
        logic signed [15:0] human_pos_x;
        logic signed [15:0] human_pos_y;
        logic signed [15:0] human_vel_x;
        logic signed [15:0] human_vel_y;
        logic        [15:0] human_radius;
        logic signed [15:0] robot_pos_x;
        logic signed [15:0] robot_pos_y;
        logic signed [15:0] robot_vel_x;
        logic signed [15:0] robot_vel_y;
        logic        [15:0] robot_radius;
    } item_t;

    typedef struct packed {
        logic [23:0] collide_time;
        logic [1:0]  outcome;
    } result_t;

    typedef enum logic [1:0] {
        KIND_OVERLAP,
        KIND_CAND,
        KIND_NONE
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [33:0] d;
        logic [33:0] vsq;
        logic [33:0] cmr;
    } job_t;

endpackage

`default_nettype wire

[hdl/dttc_fifo.sv]
// ----------------------------------------------------------------------------
// dttc_fifo
// Two-entry queue; full and empty come straight from the fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module dttc_fifo #(
    parameter type T = logic
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire T     wdata,
    output logic      full,
    input  wire logic pop,
    output T          rdata,
    output logic      empty
);

    T           mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);

endmodule

`default_nettype wire

[hdl/dttc_front.sv]
// ----------------------------------------------------------------------------
// dttc_front
// Four-stage front end: differences, products, sums, then classification.
// ----------------------------------------------------------------------------
`default_nettype none

module dttc_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire dttc_pkg::item_t item,
    input  wire logic           stall,
    output logic                job_valid,
    output dttc_pkg::job_t      job
);

    import dttc_pkg::*;

    logic adv;

    // stage 1
    logic               v1_reg;
    logic signed [16:0] cx_reg, cy_reg, vx_reg, vy_reg;
    logic        [16:0] rsum_reg;

    // stage 2
    logic               v2_reg;
    logic        [32:0] cxx_reg, cyy_reg, vxx_reg, vyy_reg;
    logic signed [33:0] vxc_reg, vyc_reg;
    logic        [33:0] rsq2_reg;

    // stage 3
    logic               v3_reg;
    logic        [33:0] csq_reg, vsq_reg, rsq3_reg;
    logic signed [34:0] vdc_reg;

    // stage 4
    logic               v4_reg;
    job_t               job_reg;
    job_t               job_next;

    logic signed [33:0] p_cxx, p_cyy, p_vxx, p_vyy, p_vxc, p_vyc;
    logic        [33:0] p_rsq;

    assign adv = !stall;

    always_comb
    begin
        p_cxx = cx_reg * cx_reg;
        p_cyy = cy_reg * cy_reg;
        p_vxx = vx_reg * vx_reg;
        p_vyy = vy_reg * vy_reg;
        p_vxc = vx_reg * cx_reg;
        p_vyc = vy_reg * cy_reg;
        p_rsq = rsum_reg * rsum_reg;
    end

    always_comb
    begin
        job_next.d   = vdc_reg[33:0];
        job_next.vsq = vsq_reg;
        job_next.cmr = csq_reg - rsq3_reg;
        if (csq_reg < rsq3_reg)
        begin
            job_next.kind = KIND_OVERLAP;
        end
        else if (!vdc_reg[34] && (vdc_reg != '0) && (vsq_reg != '0))
        begin
            job_next.kind = KIND_CAND;
        end
        else
        begin
            job_next.kind = KIND_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= push;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg   <= 17'(item.robot_pos_x) - 17'(item.human_pos_x);
            cy_reg   <= 17'(item.robot_pos_y) - 17'(item.human_pos_y);
            vx_reg   <= 17'(item.human_vel_x) - 17'(item.robot_vel_x);
            vy_reg   <= 17'(item.human_vel_y) - 17'(item.robot_vel_y);
            rsum_reg <= {1'b0, item.human_radius} + {1'b0, item.robot_radius};

            cxx_reg  <= p_cxx[32:0];
            cyy_reg  <= p_cyy[32:0];
            vxx_reg  <= p_vxx[32:0];
            vyy_reg  <= p_vyy[32:0];
            vxc_reg  <= p_vxc;
            vyc_reg  <= p_vyc;
            rsq2_reg <= p_rsq;

            csq_reg  <= {1'b0, cxx_reg} + {1'b0, cyy_reg};
            vsq_reg  <= {1'b0, vxx_reg} + {1'b0, vyy_reg};
            vdc_reg  <= 35'(vxc_reg) + 35'(vyc_reg);
            rsq3_reg <= rsq2_reg;

            job_reg  <= job_next;
        end
    end

    assign job_valid = v4_reg && adv;
    assign job       = job_reg;

endmodule

`default_nettype wire

[hdl/dttc_back.sv]
// ----------------------------------------------------------------------------
// dttc_back
// Back end: products, discriminant, bit-per-stage square root, bit-per-stage divide.
// ----------------------------------------------------------------------------
`default_nettype none

module dttc_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire dttc_pkg::job_t  job,
    input  wire logic            job_empty,
    output logic                 job_pop,
    output logic                 res_push,
    output dttc_pkg::result_t    res,
    input  wire logic            res_full
);

    import dttc_pkg::*;

    logic adv;

    // product stage
    logic              vm_reg;
    kind_t             km_reg;
    logic [ROOT_W-1:0] dm_reg, vsqm_reg;
    logic [F_W-1:0]    am_reg, bm_reg;

    // square root pipeline, index 0 is the discriminant stage
    logic              sq_valid_reg [ROOT_W+1];
    kind_t             sq_kind_reg  [ROOT_W+1];
    logic [ROOT_W-1:0] sq_d_reg     [ROOT_W+1];
    logic [ROOT_W-1:0] sq_vsq_reg   [ROOT_W+1];
    logic [F_W-1:0]    sq_rem_reg   [ROOT_W+1];
    logic [ROOT_W-1:0] sq_root_reg  [ROOT_W+1];

    // divide pipeline, index 0 is the saturation stage
    logic              dv_valid_reg [QUOT_W+1];
    kind_t             dv_kind_reg  [QUOT_W+1];
    logic              dv_sat_reg   [QUOT_W+1];
    logic [ROOT_W-1:0] dv_vsq_reg   [QUOT_W+1];
    logic [NUM_W-1:0]  dv_rem_reg   [QUOT_W+1];
    logic [QUOT_W-1:0] dv_q_reg     [QUOT_W+1];

    kind_t             k0_next, ks_next;
    logic [NUM_W-1:0]  num_next;

    assign adv     = !res_full;
    assign job_pop = adv && !job_empty;

    always_comb
    begin
        k0_next = km_reg;
        if ((km_reg == KIND_CAND) && !(am_reg > bm_reg))
        begin
            k0_next = KIND_NONE;
        end
        ks_next = sq_kind_reg[ROOT_W];
        if ((sq_kind_reg[ROOT_W] == KIND_CAND) && (sq_root_reg[ROOT_W] >= sq_d_reg[ROOT_W]))
        begin
            ks_next = KIND_NONE;
        end
        num_next = {sq_d_reg[ROOT_W] - sq_root_reg[ROOT_W], 8'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg          <= 1'b0;
            sq_valid_reg[0] <= 1'b0;
            dv_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vm_reg          <= job_pop;
            sq_valid_reg[0] <= vm_reg;
            dv_valid_reg[0] <= sq_valid_reg[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            km_reg   <= job.kind;
            dm_reg   <= job.d;
            vsqm_reg <= job.vsq;
            am_reg   <= job.d * job.d;
            bm_reg   <= job.vsq * job.cmr;

            sq_kind_reg[0] <= k0_next;
            sq_d_reg[0]    <= dm_reg;
            sq_vsq_reg[0]  <= vsqm_reg;
            sq_rem_reg[0]  <= am_reg - bm_reg;
            sq_root_reg[0] <= '0;

            dv_kind_reg[0] <= ks_next;
            dv_vsq_reg[0]  <= sq_vsq_reg[ROOT_W];
            dv_rem_reg[0]  <= num_next;
            dv_sat_reg[0]  <= {16'd0, num_next} >= {sq_vsq_reg[ROOT_W], 24'd0};
            dv_q_reg[0]    <= '0;
        end
    end

    // one root bit per stage, most significant first
    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_sqrt
        localparam int BIT = ROOT_W - 1 - g;
        logic [F_W:0] term;
        logic         take;

        always_comb
        begin
            term = ({(F_W+1-ROOT_W)'(0), sq_root_reg[g]} << (BIT + 1))
                 + ((F_W+1)'(1) << (2 * BIT));
            take = {1'b0, sq_rem_reg[g]} >= term;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[g+1] <= 1'b0;
            end
            else if (adv)
            begin
                sq_valid_reg[g+1] <= sq_valid_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_kind_reg[g+1] <= sq_kind_reg[g];
                sq_d_reg[g+1]    <= sq_d_reg[g];
                sq_vsq_reg[g+1]  <= sq_vsq_reg[g];
                if (take)
                begin
                    sq_rem_reg[g+1]  <= sq_rem_reg[g] - term[F_W-1:0];
                    sq_root_reg[g+1] <= sq_root_reg[g] | (ROOT_W'(1) << BIT);
                end
                else
                begin
                    sq_rem_reg[g+1]  <= sq_rem_reg[g];
                    sq_root_reg[g+1] <= sq_root_reg[g];
                end
            end
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar g = 0; g < QUOT_W; g++)
    begin : g_div
        localparam int BIT = QUOT_W - 1 - g;
        logic [ROOT_W+QUOT_W-1:0] term;
        logic                     take;

        always_comb
        begin
            term = {QUOT_W'(0), dv_vsq_reg[g]} << BIT;
            take = {(ROOT_W+QUOT_W-NUM_W)'(0), dv_rem_reg[g]} >= term;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[g+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_valid_reg[g+1] <= dv_valid_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_kind_reg[g+1] <= dv_kind_reg[g];
                dv_sat_reg[g+1]  <= dv_sat_reg[g];
                dv_vsq_reg[g+1]  <= dv_vsq_reg[g];
                if (take)
                begin
                    dv_rem_reg[g+1] <= dv_rem_reg[g] - term[NUM_W-1:0];
                    dv_q_reg[g+1]   <= dv_q_reg[g] | (QUOT_W'(1) << BIT);
                end
                else
                begin
                    dv_rem_reg[g+1] <= dv_rem_reg[g];
                    dv_q_reg[g+1]   <= dv_q_reg[g];
                end
            end
        end
    end

    always_comb
    begin
        unique case (dv_kind_reg[QUOT_W])
            KIND_OVERLAP:
            begin
                res.collide_time = '0;
                res.outcome      = OUTCOME_OVERLAP;
            end
            KIND_CAND:
            begin
                res.collide_time = dv_sat_reg[QUOT_W] ? TIME_MAX : dv_q_reg[QUOT_W];
                res.outcome      = OUTCOME_AHEAD;
            end
            default:
            begin
                res.collide_time = TIME_MAX;
                res.outcome      = OUTCOME_NONE;
            end
        endcase
    end

    assign res_push = dv_valid_reg[QUOT_W] && adv;

endmodule

`default_nettype wire

[hdl/disc_time_to_collision_top.sv]
// Throughput: one item per cycle, sustained while results are popped as they appear.
// Most of the latency comes from the 34-stage square root and the 24-stage divider in the back end.
// Reset clears all valid bits and queue counts; payload registers are not reset.
// ----------------------------------------------------------------------------
// disc_time_to_collision_top
// Time until two moving discs touch, front end and back end split by a queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "disc_time_to_collision_top_defines.svh"

module disc_time_to_collision_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire dttc_pkg::item_t   item,
    output logic                   full,
    output dttc_pkg::result_t      result,
    output logic                   empty,
    input  wire logic              pop
);

    import dttc_pkg::*;

    logic    job_valid;
    job_t    job_in, job_out;
    logic    mid_full, mid_empty, mid_pop;
    logic    res_push, out_full;
    result_t res;

    dttc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .stall     (mid_full),
        .job_valid (job_valid),
        .job       (job_in)
    );

    dttc_fifo #(.T(job_t)) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_valid),
        .wdata (job_in),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (job_out),
        .empty (mid_empty)
    );

    dttc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_out),
        .job_empty (mid_empty),
        .job_pop   (mid_pop),
        .res_push  (res_push),
        .res       (res),
        .res_full  (out_full)
    );

    dttc_fifo #(.T(result_t)) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (out_full),
        .pop   (pop && !empty),
        .rdata (result),
        .empty (empty)
    );

    assign full = mid_full;

    `DTTC_ASSERT_IMPLY(a_out_q_no_overrun, res_push, !out_full)
    `DTTC_ASSERT_IMPLY(a_mid_q_no_overrun, job_valid, !mid_full)
    `DTTC_ASSERT_IMPLY(a_overlap_zero_time, !empty && (result.outcome == OUTCOME_OVERLAP), result.collide_time == '0)
    `DTTC_ASSERT_IMPLY(a_none_max_time, !empty && (result.outcome == OUTCOME_NONE), result.collide_time == TIME_MAX)

endmodule

`default_nettype wire

[verif/tb_disc_time_to_collision_top.sv]
// ----------------------------------------------------------------------------
// tb_disc_time_to_collision_top
// Self-checking bench for the disc time-to-collision block: a directed table
// of edge cases, then bursts of random disc pairs, each result checked against
// the table's known result or a bit-exact integer prediction of the contact time.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_disc_time_to_collision_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dttc_pkg::*;

    localparam int N_RANDOM = 1650;
    localparam int LATENCY  = 66;

    typedef struct {
        item_t   it;
        bit      known;
        result_t res;
    } row_t;

    logic    clk;
    logic    rst_n;
    logic    push;
    item_t   item;
    logic    full;
    result_t result;
    logic    empty;
    logic    pop;

    result_t expected_q[$];
    int      mismatches;
    int      stray_results;
    bit      hold_off;
    row_t    rows[$];

    disc_time_to_collision_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .result (result),
        .empty  (empty),
        .pop    (pop)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // floor square root, f below 2^72
    function automatic logic [36:0] isqrt(logic [127:0] f);
        logic [36:0]  root;
        logic [36:0]  cand;
        root = '0;
        for (int b = 36; b >= 0; b--)
        begin
            cand = root | (37'd1 << b);
            if ({91'd0, cand} * {91'd0, cand} <= f)
                root = cand;
        end
        return root;
    endfunction

    function automatic result_t contact_time(item_t it);
        result_t            r;
        logic signed [63:0] cx, cy, vx, vy, vdc;
        logic [63:0]        rsum, rsq, csq, vsq, s, t;
        logic [127:0]       a, b;
        cx   = 64'(it.robot_pos_x) - 64'(it.human_pos_x);
        cy   = 64'(it.robot_pos_y) - 64'(it.human_pos_y);
        vx   = 64'(it.human_vel_x) - 64'(it.robot_vel_x);
        vy   = 64'(it.human_vel_y) - 64'(it.robot_vel_y);
        rsum = 64'(it.human_radius) + 64'(it.robot_radius);
        rsq  = rsum * rsum;
        csq  = cx * cx + cy * cy;
        vdc  = vx * cx + vy * cy;
        r.collide_time = TIME_MAX;
        r.outcome      = OUTCOME_NONE;
        if (csq < rsq)
        begin
            r.collide_time = '0;
            r.outcome      = OUTCOME_OVERLAP;
        end
        else if (vdc > 0)
        begin
            vsq = vx * vx + vy * vy;
            a   = {64'd0, vdc} * {64'd0, vdc};
            b   = {64'd0, vsq} * {64'd0, csq - rsq};
            if (vsq != 0 && a > b)
            begin
                s = 64'(isqrt(a - b));
                if (s < vdc)
                begin
                    t = ((64'(vdc) - s) << 8) / vsq;
                    r.collide_time = (t > 64'(TIME_MAX)) ? TIME_MAX : t[23:0];
                    r.outcome      = OUTCOME_AHEAD;
                end
            end
        end
        return r;
    endfunction

    function automatic item_t mk(int hx, int hy, int hvx, int hvy, int hr,
                                 int rx, int ry, int rvx, int rvy, int rr);
        item_t it;
        it.human_pos_x  = hx[15:0];
        it.human_pos_y  = hy[15:0];
        it.human_vel_x  = hvx[15:0];
        it.human_vel_y  = hvy[15:0];
        it.human_radius = hr[15:0];
        it.robot_pos_x  = rx[15:0];
        it.robot_pos_y  = ry[15:0];
        it.robot_vel_x  = rvx[15:0];
        it.robot_vel_y  = rvy[15:0];
        it.robot_radius = rr[15:0];
        return it;
    endfunction

    function automatic item_t random_pair();
        item_t it;
        int    k;
        it = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        k  = $urandom_range(0, 9);
        if (k < 6)
        begin
            // near-miss geometry: short range, modest speeds, modest radii
            it.human_pos_x  = 16'($signed($urandom_range(0, 8000)) - 4000);
            it.human_pos_y  = 16'($signed($urandom_range(0, 8000)) - 4000);
            it.robot_pos_x  = 16'($signed($urandom_range(0, 8000)) - 4000);
            it.robot_pos_y  = 16'($signed($urandom_range(0, 8000)) - 4000);
            it.human_vel_x  = 16'($signed($urandom_range(0, 2000)) - 1000);
            it.human_vel_y  = 16'($signed($urandom_range(0, 2000)) - 1000);
            it.robot_vel_x  = 16'($signed($urandom_range(0, 2000)) - 1000);
            it.robot_vel_y  = 16'($signed($urandom_range(0, 2000)) - 1000);
            it.human_radius = 16'($urandom_range(0, 1500));
            it.robot_radius = 16'($urandom_range(0, 1500));
        end
        else if (k < 8)
        begin
            it.human_radius = 16'($urandom_range(0, 300));
            it.robot_radius = 16'($urandom_range(0, 300));
        end
        return it;
    endfunction

    task automatic send(item_t it, bit known, result_t res);
        result_t exp_r;
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        exp_r = known ? res : contact_time(it);
        expected_q.insert(expected_q.size(), exp_r);
    endtask

    // sender bursts: drop push only during gaps
    task automatic maybe_gap();
        if ($urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    initial
    begin
        result_t none_r;
        result_t over_r;
        none_r.collide_time = TIME_MAX;
        none_r.outcome      = OUTCOME_NONE;
        over_r.collide_time = '0;
        over_r.outcome      = OUTCOME_OVERLAP;
        rows = '{
            '{mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, none_r},
            '{mk(0, 0, 0, 0, 10, 0, 0, 0, 0, 0), 1'b1, over_r},
            '{mk(0, 0, 0, 0, 65535, 0, 0, 0, 0, 65535), 1'b1, over_r},
            '{mk(0, 0, 256, 0, 100, 1000, 0, 0, 0, 100), 1'b0, none_r},
            '{mk(0, 0, -256, 0, 100, 1000, 0, 0, 0, 100), 1'b1, none_r},
            '{mk(0, 0, 256, 0, 100, 1000, 5000, 0, 0, 100), 1'b1, none_r},
            '{mk(0, 0, 256, 0, 100, 300, 0, 0, 0, 100), 1'b0, none_r},
            '{mk(0, 0, 256, 0, 100, 1000, 200, 0, 0, 100), 1'b0, none_r},
            '{mk(0, 0, 32767, 0, 0, 2, 0, -32768, 0, 1), 1'b0, none_r},
            '{mk(-32768, -32768, 1, 1, 0, 32767, 32767, 0, 0, 0), 1'b0, none_r},
            '{mk(-32768, 0, 1, 0, 1, 32767, 0, 0, 0, 1), 1'b0, none_r},
            '{mk(32767, 32767, -32768, -32768, 0, -32768, -32768, 32767, 32767, 0),
              1'b0, none_r},
            '{mk(-32768, -32768, 32767, 32767, 65535, 32767, 32767, -32768, -32768, 0),
              1'b0, none_r},
            '{mk(0, 0, 0, 0, 0, 32767, 0, 0, 0, 0), 1'b1, none_r},
            '{mk(0, 0, 0, 1, 0, 0, 1, 0, 0, 0), 1'b0, none_r},
            '{mk(0, 0, 0, 0, 1, 0, 1, 0, 0, 0), 1'b1, none_r},
            '{mk(0, 0, 0, 0, 2, 0, 1, 0, 0, 0), 1'b1, over_r},
            '{mk(1, -1, -32768, 32767, 32768, -2, 2, 0, 0, 32767), 1'b0, none_r}
        };
    end

    // receiver: own stall pattern, plus one long hold-off
    initial
    begin
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                pop <= 1'b0;
            else
                case ($urandom_range(0, 3))
                    0: pop <= 1'b0;
                    default: pop <= 1'b1;
                endcase
        end
    end

    initial
    begin
        hold_off = 1'b0;
        @(posedge rst_n);
        repeat (400) @(posedge clk);
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_q.size() == 0)
            begin
                stray_results++;
                if (mismatches + stray_results <= 10)
                    $display("unexpected result %h", result);
            end
            else
            begin
                result_t exp_r;
                exp_r = expected_q.pop_front();
                if (result.collide_time !== exp_r.collide_time
                    || result.outcome !== exp_r.outcome)
                begin
                    mismatches++;
                    if (mismatches + stray_results <= 10)
                        $display("mismatch: expected time %0d outcome %0d, got %0d %0d",
                                 exp_r.collide_time, exp_r.outcome,
                                 result.collide_time, result.outcome);
                end
            end
        end
    end

    initial
    begin
        mismatches    = 0;
        stray_results = 0;
        rst_n         = 1'b0;
        push          <= 1'b0;
        item          <= '0;
        repeat (7) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);
        foreach (rows[i])
        begin
            send(rows[i].it, rows[i].known, rows[i].res);
            maybe_gap();
        end
        for (int n = 0; n < N_RANDOM; n++)
        begin
            send(random_pair(), 1'b0, '0);
            if ($urandom_range(0, 1) == 0)
                maybe_gap();
        end
        push <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && stray_results == 0 && expected_q.size() == 0)
            $display("PASS disc_time_to_collision_top");
        else
            $display("FAIL disc_time_to_collision_top");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("FAIL disc_time_to_collision_top");
        $finish;
    end

endmodule

`default_nettype wire
